// ----- src/tbop_pkg.sv -----
// ----------------------------------------------------------------------------
// tbop_pkg
// Shared types and constants for the timer bank
// ----------------------------------------------------------------------------
package tbop_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W = 4;
  localparam int TIME_W = 32;
  localparam int REM_W = 33;
  localparam int CNT_W = 8;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ONESHOT = 2'd1,
    FUNC_PERIODIC = 2'd2,
    FUNC_STOP = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_STARTED = 3'd0,
    KIND_NOSLOT = 3'd1,
    KIND_BADPERIOD = 3'd2,
    KIND_FIRED = 3'd3,
    KIND_NONE = 3'd4,
    KIND_STOPPED = 3'd5,
    KIND_NOTACTIVE = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_REPORT,
    ST_NONE
  } state_t;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic shift;
    logic [REM_W-1:0] head_rem;
    logic [TIME_W-1:0] load_per;
  } cell_ctrl_t;

endpackage

// ----- src/tbop_cell.sv -----
// ----------------------------------------------------------------------------
// tbop_cell
// One timer slot; in scan mode it takes the state of its upper neighbor
// ----------------------------------------------------------------------------
module tbop_cell
  import tbop_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift,
  input  logic                    in_busy,
  input  logic [REM_W-1:0]        in_rem,
  input  logic [TIME_W-1:0]       in_per,
  input  logic                    wr,
  input  logic                    wr_busy,
  input  logic [REM_W-1:0]        wr_rem,
  input  logic [TIME_W-1:0]       wr_per,
  output logic                    busy,
  output logic [REM_W-1:0]        rem,
  output logic [TIME_W-1:0]       per
);

  logic busy_r;
  logic [REM_W-1:0] rem_r;
  logic [TIME_W-1:0] per_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (shift) begin
      busy_r <= in_busy;
    end else if (wr) begin
      busy_r <= wr_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      rem_r <= in_rem;
      per_r <= in_per;
    end else if (wr) begin
      rem_r <= wr_rem;
      per_r <= wr_per;
    end
  end

  assign busy = busy_r;
  assign rem = rem_r;
  assign per = per_r;

endmodule

// ----- src/tbop_div.sv -----
// ----------------------------------------------------------------------------
// tbop_div
// Restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tbop_div
  import tbop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [TIME_W-1:0] num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [TIME_W-1:0] quo,
  output logic [TIME_W-1:0] rmd
);

  logic [TIME_W-1:0] q_r, q_nxt;
  logic [TIME_W:0] r_r, r_nxt;
  logic [TIME_W-1:0] d_r;
  logic [STEP_W-1:0] n_r, n_nxt;
  logic run_r, run_nxt;
  logic [TIME_W:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    n_nxt = n_r;
    run_nxt = run_r;
    trial = {r_r[TIME_W-1:0], q_r[TIME_W-1]} - {1'b0, d_r};
    if (go) begin
      q_nxt = num;
      r_nxt = '0;
      n_nxt = STEP_W'(DIV_STEPS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[TIME_W]) begin
        r_nxt = trial;
        q_nxt = {q_r[TIME_W-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[TIME_W-1:0], q_r[TIME_W-1]};
        q_nxt = {q_r[TIME_W-2:0], 1'b0};
      end
      n_nxt = n_r - STEP_W'(1);
      if (n_r == STEP_W'(1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    n_r <= n_nxt;
    if (go) begin
      d_r <= den;
    end
  end

  assign done = run_r && (n_r == STEP_W'(1));
  assign quo = q_nxt;
  assign rmd = r_nxt[TIME_W-1:0];

endmodule

// ----- src/timer_bank_oneshot_periodic_core.sv -----
// ----------------------------------------------------------------------------
// timer_bank_oneshot_periodic_core
// Sixteen one-shot or periodic timers with lowest-free slot allocation
// ----------------------------------------------------------------------------
// Start, stop and tick commands are taken while busy is low; each result is
// shown for one cycle on out_valid and must be taken then, the receiver cannot
// stall. The slots sit in a ring of cells. After a start or stop, busy stays high
// in ST_NONE alone and the result comes in that state. A tick rotates the ring
// once through slot 0, one slot per cycle except while the shared bit-serial
// divider works for a periodic timer that fires (ST_DIV); busy stays high to the
// end of ST_NONE and the final result comes in the last busy cycle.
module timer_bank_oneshot_periodic_core
  import tbop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_func,
  input  logic [TIME_W-1:0] in_time_value,
  input  logic [SLOT_W-1:0] in_timer_id,
  output logic              out_valid,
  output logic [2:0]        out_kind,
  output logic [SLOT_W-1:0] out_slot,
  output logic [CNT_W-1:0]  out_fire_count,
  output logic              out_last
);

  logic [NUM_TIMERS-1:0] c_busy;
  logic [REM_W-1:0] c_rem [NUM_TIMERS];
  logic [TIME_W-1:0] c_per [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] c_wr;
  logic [NUM_TIMERS-1:0] c_wbusy;
  cell_ctrl_t ctl;

  state_t state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [TIME_W-1:0] dt_r;
  logic [REM_W-1:0] hrem_r, hrem_nxt;
  logic hold_r, hold_nxt;
  logic [CNT_W-1:0] hcnt_r, hcnt_nxt;

  logic h_busy;
  logic [REM_W-1:0] h_rem;
  logic [CNT_W-1:0] h_cnt;
  logic h_fire;

  logic ov_r, ov_nxt;
  kind_t ok_r, ok_nxt;
  logic [SLOT_W-1:0] os_r, os_nxt;
  logic [CNT_W-1:0] oc_r, oc_nxt;
  logic ol_r, ol_nxt;
  logic pv_r, pv_nxt;
  logic [SLOT_W-1:0] ps_r, ps_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;

  logic div_go, div_done;
  logic [TIME_W-1:0] div_q, div_r;
  logic [TIME_W-1:0] over;
  logic accept;
  logic fire_hit;
  logic need_div;
  logic div_fin;
  logic free_found;
  logic [SLOT_W-1:0] free_slot;

  // rotate: cell i takes cell i+1, the top cell takes the processed head
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    logic nb;
    logic [REM_W-1:0] nr;
    logic [TIME_W-1:0] np;
    if (g == NUM_TIMERS - 1) begin : g_top
      assign nb = h_busy;
      assign nr = h_rem;
      assign np = c_per[0];
    end else begin : g_mid
      assign nb = c_busy[g+1];
      assign nr = c_rem[g+1];
      assign np = c_per[g+1];
    end
    tbop_cell u_cell (
      .clk(clk), .rst_n(rst_n), .shift(ctl.shift),
      .in_busy(nb), .in_rem(nr), .in_per(np),
      .wr(c_wr[g]), .wr_busy(c_wbusy[g]),
      .wr_rem(ctl.head_rem), .wr_per(ctl.load_per),
      .busy(c_busy[g]), .rem(c_rem[g]), .per(c_per[g])
    );
  end

  tbop_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go),
    .num(over), .den(c_per[0]),
    .done(div_done), .quo(div_q), .rmd(div_r)
  );

  always_comb begin
    free_found = 1'b0;
    free_slot = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!c_busy[i]) begin
        free_found = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign over = dt_r - c_rem[0][TIME_W-1:0];
  assign fire_hit = c_busy[0] && ({1'b0, dt_r} >= c_rem[0]);
  assign need_div = (state_r == ST_SCAN) && fire_hit && (c_per[0] != '0) && !hold_r;
  assign div_go = need_div;
  assign div_fin = (state_r == ST_DIV) && div_done;

  always_comb begin
    c_wr = '0;
    c_wbusy = '0;
    ctl = '0;
    ctl.load_per = in_time_value;
    ctl.head_rem = {1'b0, in_time_value};
    if (accept && in_func == FUNC_STOP) begin
      c_wr[in_timer_id] = c_busy[in_timer_id];
      c_wbusy[in_timer_id] = 1'b0;
      ctl.head_rem = c_rem[in_timer_id];
      ctl.load_per = c_per[in_timer_id];
    end else if (accept && free_found
                 && (in_func == FUNC_ONESHOT
                     || (in_func == FUNC_PERIODIC && in_time_value != '0))) begin
      c_wr[free_slot] = 1'b1;
      c_wbusy[free_slot] = 1'b1;
      if (in_func == FUNC_ONESHOT) begin
        ctl.load_per = '0;
      end
    end
    ctl.shift = (state_r == ST_SCAN) && !need_div;
  end

  // head processing of slot 0
  always_comb begin
    h_busy = c_busy[0];
    h_rem = c_rem[0];
    h_cnt = '0;
    h_fire = 1'b0;
    if (hold_r) begin
      h_busy = 1'b1;
      h_rem = hrem_r;
      h_cnt = hcnt_r;
      h_fire = 1'b1;
    end else if (fire_hit && c_per[0] == '0) begin
      h_busy = 1'b0;
      h_rem = '0;
      h_cnt = CNT_W'(1);
      h_fire = 1'b1;
    end else if (c_busy[0] && !fire_hit) begin
      h_rem = c_rem[0] - {1'b0, dt_r};
    end
  end

  // count = q + 1, remaining = p - r
  always_comb begin
    hold_nxt = div_fin;
    hrem_nxt = hrem_r;
    hcnt_nxt = hcnt_r;
    if (div_fin) begin
      hrem_nxt = {1'b0, c_per[0] - div_r};
      hcnt_nxt = (div_q >= TIME_W'(255)) ? '1 : CNT_W'(div_q + TIME_W'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          state_nxt = (in_func == FUNC_TICK) ? ST_SCAN : ST_NONE;
        end
      end
      ST_SCAN: begin
        if (need_div) begin
          state_nxt = ST_DIV;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
          if (idx_r == SLOT_W'(NUM_TIMERS - 1)) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_REPORT: begin
        state_nxt = ST_NONE;
      end
      ST_NONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // the latest fired result is held until it is known whether it is last
  always_comb begin
    ov_nxt = 1'b0;
    ok_nxt = ok_r;
    os_nxt = os_r;
    oc_nxt = oc_r;
    ol_nxt = ol_r;
    pv_nxt = pv_r;
    ps_nxt = ps_r;
    pc_nxt = pc_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pv_nxt = 1'b0;
          oc_nxt = '0;
          ol_nxt = 1'b1;
          case (in_func)
            FUNC_TICK: begin
              ov_nxt = 1'b0;
            end
            FUNC_ONESHOT, FUNC_PERIODIC: begin
              ov_nxt = 1'b1;
              os_nxt = '0;
              if (in_func == FUNC_PERIODIC && in_time_value == '0) begin
                ok_nxt = KIND_BADPERIOD;
              end else if (!free_found) begin
                ok_nxt = KIND_NOSLOT;
              end else begin
                ok_nxt = KIND_STARTED;
                os_nxt = free_slot;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              os_nxt = in_timer_id;
              ok_nxt = c_busy[in_timer_id] ? KIND_STOPPED : KIND_NOTACTIVE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (h_fire) begin
          if (pv_r) begin
            ov_nxt = 1'b1;
            ok_nxt = KIND_FIRED;
            os_nxt = ps_r;
            oc_nxt = pc_r;
            ol_nxt = 1'b0;
          end
          pv_nxt = 1'b1;
          ps_nxt = idx_r;
          pc_nxt = h_cnt;
        end
      end
      ST_REPORT: begin
        ov_nxt = 1'b1;
        ol_nxt = 1'b1;
        pv_nxt = 1'b0;
        if (pv_r) begin
          ok_nxt = KIND_FIRED;
          os_nxt = ps_r;
          oc_nxt = pc_r;
        end else begin
          ok_nxt = KIND_NONE;
          os_nxt = '0;
          oc_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hold_r <= 1'b0;
      ov_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hold_r <= hold_nxt;
      ov_r <= ov_nxt;
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hrem_r <= hrem_nxt;
    hcnt_r <= hcnt_nxt;
    ok_r <= ok_nxt;
    os_r <= os_nxt;
    oc_r <= oc_nxt;
    ol_r <= ol_nxt;
    ps_r <= ps_nxt;
    pc_r <= pc_nxt;
    if (accept && in_func == FUNC_TICK) begin
      dt_r <= in_time_value;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_slot = os_r;
  assign out_fire_count = oc_r;
  assign out_last = ol_r;

  // no transaction is taken while a command is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept) else $error("accept while busy");

  // fire count is only set on fired results
  a_cnt_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_FIRED) |-> out_fire_count == '0)
    else $error("fire count on non-fired result");

  // start and stop answer with one final result
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func != FUNC_TICK) |=> (out_valid && out_last))
    else $error("missing command result");

  // results only come while a command is in progress
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for timer_bank_oneshot_periodic_core
// ----------------------------------------------------------------------------
// A queue of commands (directed, then random) feeds a falling-edge driver that
// sends them in bursts with random gaps. Each accepted command is run through
// a behavioral model of the timer bank, and the results it gives are queued.
// A rising-edge monitor compares every result strobe with the oldest queued
// result, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import tbop_pkg::*;
();

  typedef struct packed {
    logic [1:0]        func;
    logic [TIME_W-1:0] tval;
    logic [SLOT_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_func = '0;
  logic [TIME_W-1:0] in_time_value = '0;
  logic [SLOT_W-1:0] in_timer_id = '0;
  logic              out_valid;
  logic [2:0]        out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_fire_count;
  logic              out_last;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_fired = 0;
  int   burst_left = 0;
  int   gap_left = 0;

  // marks that the driven command was taken at the last rising edge, or that none was driven
  bit busy_seen = 1'b1;

  bit              mdl_busy[NUM_TIMERS];
  logic [63:0]     mdl_rem[NUM_TIMERS];
  logic [TIME_W-1:0] mdl_per[NUM_TIMERS];

  timer_bank_oneshot_periodic_core DUT (.*);

  always #5 clk = ~clk;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %0d at %0t: %s got %0d expected %0d", errors, $realtime, what, got,
             want);
  endtask

  function automatic void exp_add(input res_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void cmd_add(input cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic res_t mk(input kind_t k, input int s, input int c, input bit l);
    res_t r;
    r.kind = k;
    r.slot = s[SLOT_W-1:0];
    r.cnt = c[CNT_W-1:0];
    r.last = l;
    return r;
  endfunction

  task automatic predict_timer_bank(input cmd_t c);
    int i;
    int n;
    bit done;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] k;
    res_t t;
    done = 0;
    n = 0;
    case (c.func)
      FUNC_TICK: begin
        for (i = 0; i < NUM_TIMERS; i++) begin
          if (mdl_busy[i]) begin
            if (64'(c.tval) < mdl_rem[i]) begin
              mdl_rem[i] -= 64'(c.tval);
            end else begin
              if (mdl_per[i] == 0) begin
                k = 1;
                mdl_busy[i] = 0;
                mdl_rem[i] = 0;
              end else begin
                p = 64'(mdl_per[i]);
                d = 64'(c.tval) - mdl_rem[i];
                k = d / p + 1;
                mdl_rem[i] = k * p - d;
              end
              exp_add(mk(KIND_FIRED, i, (k > 255) ? 255 : int'(k), 0));
              n++;
              n_fired++;
            end
          end
        end
        if (n == 0) begin
          exp_add(mk(KIND_NONE, 0, 0, 1));
        end else begin
          t = expected_results.pop_back();
          t.last = 1'b1;
          exp_add(t);
        end
      end
      FUNC_ONESHOT, FUNC_PERIODIC: begin
        if (c.func == FUNC_PERIODIC && c.tval == 0) begin
          exp_add(mk(KIND_BADPERIOD, 0, 0, 1));
        end else begin
          for (i = 0; i < NUM_TIMERS; i++) begin
            if (!done && !mdl_busy[i]) begin
              done = 1;
              mdl_busy[i] = 1;
              mdl_rem[i] = 64'(c.tval);
              mdl_per[i] = (c.func == FUNC_PERIODIC) ? c.tval : '0;
              exp_add(mk(KIND_STARTED, i, 0, 1));
            end
          end
          if (!done) exp_add(mk(KIND_NOSLOT, 0, 0, 1));
        end
      end
      default: begin
        if (mdl_busy[c.id]) begin
          mdl_busy[c.id] = 0;
          exp_add(mk(KIND_STOPPED, c.id, 0, 1));
        end else begin
          exp_add(mk(KIND_NOTACTIVE, c.id, 0, 1));
        end
      end
    endcase
  endtask

  function automatic cmd_t mkcmd(input func_t f, input logic [31:0] v, input int id);
    cmd_t c;
    c.func = f;
    c.tval = v;
    c.id = id[SLOT_W-1:0];
    return c;
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 100);
      2: return $urandom_range(0, 2000);
      3: return $urandom;
      4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(1, 50000);
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy_seen) begin
        // previous command still pending, hold
      end else begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_func <= pending_cmds[0].func;
          in_time_value <= pending_cmds[0].tval;
          in_timer_id <= pending_cmds[0].id;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy && pending_cmds.size() > 0) begin
        predict_timer_bank(pending_cmds.pop_front());
        n_sent++;
        busy_seen <= 1'b1;
      end else if (start) begin
        busy_seen <= 1'b0;
      end else begin
        busy_seen <= 1'b1;
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report("result with nothing expected, kind", 32'(out_kind), 32'd0);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_kind !== e.kind) report("kind", 32'(out_kind), 32'(e.kind));
          if (out_slot !== e.slot) report("slot", 32'(out_slot), 32'(e.slot));
          if (out_fire_count !== e.cnt) begin
            report("fire_count", 32'(out_fire_count), 32'(e.cnt));
          end
          if (out_last !== e.last) report("last", 32'(out_last), 32'(e.last));
          n_checked++;
        end
      end
    end
  end

  initial begin
    int i;
    int r;
    for (i = 0; i < NUM_TIMERS; i++) begin
      mdl_busy[i] = 0;
      mdl_rem[i] = 0;
      mdl_per[i] = 0;
    end
    // directed
    cmd_add(mkcmd(FUNC_TICK, 32'd0, 0));
    cmd_add(mkcmd(FUNC_PERIODIC, 32'd0, 0));
    cmd_add(mkcmd(FUNC_STOP, 32'd0, 15));
    cmd_add(mkcmd(FUNC_ONESHOT, 32'd0, 0));
    cmd_add(mkcmd(FUNC_TICK, 32'd0, 0));
    cmd_add(mkcmd(FUNC_PERIODIC, 32'd1, 0));
    cmd_add(mkcmd(FUNC_TICK, 32'd1000, 0));
    cmd_add(mkcmd(FUNC_PERIODIC, 32'hFFFF_FFFF, 0));
    cmd_add(mkcmd(FUNC_ONESHOT, 32'hFFFF_FFFF, 0));
    cmd_add(mkcmd(FUNC_TICK, 32'hFFFF_FFFF, 5));
    for (i = 0; i < 16; i++)
      cmd_add(mkcmd(FUNC_PERIODIC, 32'd3 + i, 15 - i));
    cmd_add(mkcmd(FUNC_ONESHOT, 32'd7, 0));
    cmd_add(mkcmd(FUNC_TICK, 32'hFFFF_FFFF, 0));
    cmd_add(mkcmd(FUNC_STOP, 32'hFFFF_FFFF, 0));
    cmd_add(mkcmd(FUNC_STOP, 32'd0, 0));
    // random: mostly starts and ticks with some stops
    for (r = 0; r < 290; r++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: cmd_add(mkcmd(FUNC_ONESHOT, rand_time(), $urandom));
        3, 4: cmd_add(mkcmd(FUNC_PERIODIC, rand_time(), $urandom));
        5, 6, 7: cmd_add(mkcmd(FUNC_TICK, rand_time(), $urandom));
        default: cmd_add(mkcmd(FUNC_STOP, $urandom, $urandom));
      endcase
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0);
    wait (expected_results.size() == 0);
    repeat (700) @(posedge clk);
    $display("sent %0d commands, checked %0d results, %0d timer firings", n_sent, n_checked,
             n_fired);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** timer_bank_oneshot_periodic_core: PASSED **");
    end else begin
      $display("** timer_bank_oneshot_periodic_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("** timer_bank_oneshot_periodic_core: FAILED **");
    $finish;
  end
endmodule
